// ===== src/wit_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and coefficient tables for the Winograd input tile transform.
package wit_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_BITS     = 16;
  localparam int VALUE_BITS  = 28;
  localparam int LANES       = 8;
  localparam int SMALL_LANES = 4;
  localparam int STORE_BITS  = SAMPLE_BITS + 6;
  localparam int ROW_BITS    = LANES * STORE_BITS;
  localparam int ROW_AW      = $clog2(LANES);
  localparam int COEF_BITS   = 6;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STORE_BITS-1:0]  store_t;
  typedef store_t [LANES-1:0]            row_t;
  typedef logic signed [VALUE_BITS-1:0]  value_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [ROW_AW-1:0]             row_idx_t;

  localparam row_idx_t LAST_LARGE = row_idx_t'(LANES - 1);
  localparam row_idx_t LAST_SMALL = row_idx_t'(SMALL_LANES - 1);

  typedef struct packed {
    logic signed [IN_BITS-1:0] sample7;
    logic signed [IN_BITS-1:0] sample6;
    logic signed [IN_BITS-1:0] sample5;
    logic signed [IN_BITS-1:0] sample4;
    logic signed [IN_BITS-1:0] sample3;
    logic signed [IN_BITS-1:0] sample2;
    logic signed [IN_BITS-1:0] sample1;
    logic signed [IN_BITS-1:0] sample0;
  } in_item_t;

  typedef struct packed {
    value_t   value7;
    value_t   value6;
    value_t   value5;
    value_t   value4;
    value_t   value3;
    value_t   value2;
    value_t   value1;
    value_t   value0;
    row_idx_t row_index;
    logic     last_row;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic big;
  } col_cmd_t;

  typedef struct packed {
    logic     en;
    row_idx_t addr;
  } rd_req_t;

  // 4 x BT for the 8x8 tile, indexed [output][input]
  localparam coef_t COEF_LARGE [LANES][LANES] = '{
    '{ 6'sd4,  6'sd0, -6'sd21,  6'sd0,  6'sd21,  6'sd0, -6'sd4, 6'sd0},
    '{ 6'sd0,  6'sd4,  6'sd4,  -6'sd17, -6'sd17, 6'sd4,  6'sd4, 6'sd0},
    '{ 6'sd0, -6'sd4,  6'sd4,   6'sd17, -6'sd17, -6'sd4, 6'sd4, 6'sd0},
    '{ 6'sd0,  6'sd2,  6'sd1,  -6'sd10, -6'sd5,  6'sd8,  6'sd4, 6'sd0},
    '{ 6'sd0, -6'sd2,  6'sd1,   6'sd10, -6'sd5, -6'sd8,  6'sd4, 6'sd0},
    '{ 6'sd0,  6'sd8,  6'sd16, -6'sd10, -6'sd20, 6'sd2,  6'sd4, 6'sd0},
    '{ 6'sd0, -6'sd8,  6'sd16,  6'sd10, -6'sd20, -6'sd2, 6'sd4, 6'sd0},
    '{ 6'sd0, -6'sd4,  6'sd0,   6'sd21,  6'sd0, -6'sd21, 6'sd0, 6'sd4}
  };

  // BT for the 4x4 tile, padded with zeros
  localparam coef_t COEF_SMALL [LANES][LANES] = '{
    '{6'sd1,  6'sd0, -6'sd1, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd1,  6'sd1, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0, -6'sd1,  6'sd1, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd1,  6'sd0, -6'sd1, 6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd0,  6'sd0, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd0,  6'sd0, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd0,  6'sd0, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{6'sd0,  6'sd0,  6'sd0, 6'sd0,  6'sd0, 6'sd0, 6'sd0, 6'sd0}
  };

  function automatic coef_t coef(input logic big, input row_idx_t r, input row_idx_t k);
    return big ? COEF_LARGE[r][k] : COEF_SMALL[r][k];
  endfunction

  // Take the low SAMPLE_BITS of a field as a signed sample
  function automatic sample_t sample_ext(input logic [IN_BITS-1:0] raw);
    sample_t v;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      v[i] = (i < IN_BITS) ? raw[i % IN_BITS] : 1'b0;
    end
    return v;
  endfunction

  // Sign-extend or wrap a stored value to result width
  function automatic value_t widen(input store_t s);
    value_t v;
    for (int i = 0; i < VALUE_BITS; i++) begin
      v[i] = s[(i < STORE_BITS) ? i : STORE_BITS - 1];
    end
    return v;
  endfunction

endpackage

// ===== src/wit_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wit_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wit_row_pass.sv =====
`timescale 1ns / 1ps
// Row transform: applies BT (scaled by 4 in large mode) to one incoming tile row.
module wit_row_pass (
  input  wit_pkg::in_item_t item_i,
  input  logic              big_i,
  output wit_pkg::row_t     row_o
);
  import wit_pkg::*;

  sample_t d [LANES];
  store_t  acc;

  always_comb begin
    d[0] = sample_ext(item_i.sample0);
    d[1] = sample_ext(item_i.sample1);
    d[2] = sample_ext(item_i.sample2);
    d[3] = sample_ext(item_i.sample3);
    d[4] = sample_ext(item_i.sample4);
    d[5] = sample_ext(item_i.sample5);
    d[6] = sample_ext(item_i.sample6);
    d[7] = sample_ext(item_i.sample7);
    acc  = '0;
    row_o = '0;
    for (int r = 0; r < LANES; r++) begin
      acc = '0;
      for (int k = 0; k < LANES; k++) begin
        acc = acc + STORE_BITS'(coef(big_i, row_idx_t'(r), row_idx_t'(k)))
                    * STORE_BITS'(d[k]);
      end
      row_o[r] = acc;
    end
  end

endmodule

// ===== src/wit_col_pass.sv =====
`timescale 1ns / 1ps
// Column pass: reads stored rows, accumulates each result row and holds it for output.
module wit_col_pass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wit_pkg::col_cmd_t  cmd_i,
  output wit_pkg::rd_req_t   rd_o,
  input  wit_pkg::row_t      rdata_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wit_pkg::out_item_t out_data_o
);
  import wit_pkg::*;

  logic      running_q, running_d;
  logic      big_q, big_d;
  row_idx_t  row_q, row_d;
  row_idx_t  tap_q, tap_d;
  row_idx_t  last_tap;
  logic      tap_end;
  logic      out_free;
  logic      issue;

  logic      p_valid_q;
  logic      p_first_q;
  logic      p_last_q;
  logic      p_final_q;
  row_idx_t  p_row_q;
  coef_t     p_coef_q;

  value_t    prod [LANES];
  value_t    sum [LANES];
  value_t    acc_q [LANES];
  logic      load;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  assign last_tap = big_q ? LAST_LARGE : LAST_SMALL;
  assign tap_end  = (tap_q == last_tap);
  assign out_free = !out_valid_q || !out_stall_i;
  // hold the final read of a row until the output register can take it
  assign issue    = running_q && (!tap_end || out_free);

  assign rd_o.en   = issue;
  assign rd_o.addr = tap_q;
  assign busy_o    = running_q;

  always_comb begin
    running_d = running_q;
    big_d     = big_q;
    row_d     = row_q;
    tap_d     = tap_q;
    if (cmd_i.start) begin
      running_d = 1'b1;
      big_d     = cmd_i.big;
      row_d     = '0;
      tap_d     = '0;
    end else if (issue) begin
      if (tap_end) begin
        tap_d = '0;
        row_d = row_q + row_idx_t'(1);
        if (row_q == last_tap) begin
          running_d = 1'b0;
        end
      end else begin
        tap_d = tap_q + row_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      big_q       <= 1'b1;
      row_q       <= '0;
      tap_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      big_q       <= big_d;
      row_q       <= row_d;
      tap_q       <= tap_d;
      p_valid_q   <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_first_q <= (tap_q == '0);
      p_last_q  <= tap_end;
      p_final_q <= (row_q == last_tap);
      p_row_q   <= row_q;
      p_coef_q  <= coef(big_q, row_q, tap_q);
    end
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      prod[c] = VALUE_BITS'(p_coef_q) * widen(rdata_i[c]);
      sum[c]  = (p_first_q ? value_t'(0) : acc_q[c]) + prod[c];
      // drop the upper lanes of a small tile
      if (!big_q && c >= SMALL_LANES) begin
        sum[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      acc_q <= sum;
    end
  end

  assign load = p_valid_q && p_last_q;

  always_comb begin
    out_d           = out_q;
    out_d.value0    = sum[0];
    out_d.value1    = sum[1];
    out_d.value2    = sum[2];
    out_d.value3    = sum[3];
    out_d.value4    = sum[4];
    out_d.value5    = sum[5];
    out_d.value6    = sum[6];
    out_d.value7    = sum[7];
    out_d.row_index = p_row_q;
    out_d.last_row  = p_final_q;
    out_valid_d     = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/winograd_input_tile_transform.sv =====
`timescale 1ns / 1ps
// Winograd input tile transform top level: row store, row pass and column pass.
// Rows are taken one per cycle while no column pass is busy; the tile's last row starts
// a column pass that reads the row store once per cycle, unless the final read of a row
// waits for the output register: 8 reads per result row (4 in small mode), 64 reads a
// tile large, 16 small, through the single store read port; input stalls meanwhile.
// Reset sets large mode, clears the row count and sequencer; the row store is not cleared.
module winograd_input_tile_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wit_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wit_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import wit_pkg::*;

  logic     large_tile_q, large_tile_d;
  row_idx_t rows_q, rows_d;
  logic     in_accept;
  logic     tile_end;
  logic     busy;
  row_t     row_wdata;
  row_t     row_rdata;
  rd_req_t  rd_req;
  col_cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign tile_end    = large_tile_q ? (rows_q == LAST_LARGE) : (rows_q >= LAST_SMALL);

  assign cmd.start = in_accept && tile_end;
  assign cmd.big   = large_tile_q;

  always_comb begin
    large_tile_d = large_tile_q;
    rows_d       = rows_q;
    if (cfg_valid_i && cfg_ready_o) begin
      large_tile_d = cfg_data_i;
    end
    if (in_accept) begin
      rows_d = tile_end ? '0 : rows_q + row_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_tile_q <= 1'b1;
      rows_q       <= '0;
    end else begin
      large_tile_q <= large_tile_d;
      rows_q       <= rows_d;
    end
  end

  wit_row_pass u_row_pass (
    .item_i (in_data_i),
    .big_i  (large_tile_q),
    .row_o  (row_wdata)
  );

  wit_ram #(
    .Width (ROW_BITS),
    .Depth (LANES)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (rows_q),
    .wdata_i (row_wdata),
    .re_i    (rd_req.en),
    .raddr_i (rd_req.addr),
    .rdata_o (row_rdata)
  );

  wit_col_pass u_col_pass (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_o        (rd_req),
    .rdata_i     (row_rdata),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
